// ===== sv/lpmf_pkg.sv =====
// Types and constants shared by the line pattern match filter.
`timescale 1ns / 1ps

package lpmf_pkg;

	// Input item kinds.
	localparam logic [1:0] MODE_CHAR     = 2'd0;
	localparam logic [1:0] MODE_EOL      = 2'd1;
	localparam logic [1:0] MODE_NEW_FILE = 2'd2;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	// Configuration register indexes.
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_FILTER_VALUE   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_ONLY_MATCHES   = 3'd5;
	localparam int unsigned CFG_DATA_W = 64;

	// Filter comparison modes; the unused codes pass every line.
	localparam logic [2:0] FILT_NONE = 3'd0;
	localparam logic [2:0] FILT_GT   = 3'd1;
	localparam logic [2:0] FILT_LT   = 3'd2;
	localparam logic [2:0] FILT_EQ   = 3'd3;
	localparam logic [2:0] FILT_GE   = 3'd4;
	localparam logic [2:0] FILT_LE   = 3'd5;

	localparam logic [11:0] COUNT_MAX = 12'hFFF;
	localparam logic [31:0] LINE_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_byte;
	} in_beat_t;

	typedef struct packed {
		logic        match_here;
		logic        line_done;
		logic        line_passed;
		logic [11:0] match_count;
		logic [31:0] line_number;
	} out_beat_t;

endpackage

// ===== sv/line_pattern_match_filter.sv =====
// Line pattern match filter: counts non-overlapping pattern hits per text line.
`timescale 1ns / 1ps

// The block takes one text beat per clock cycle, with no bubbles while the
// output is not stalled, since each beat is handled in a single pass: an
// accepted beat lands in an input register, and from there a parallel compare
// of the newest window bytes against the configured pattern, together with
// the per-line counters, produces the result into an output register. The
// result register is loaded as the beat leaves the input register. While a
// finished result waits on a stalled output, the input register still takes
// one more beat and holds it; a held beat that owes a result then blocks the
// input until the output drains. A character beat yields a result carrying
// match_here; an end-of-line beat (or the byte 0x0A) yields the line's hit
// count, its one-based line number and the filter verdict. A new-file beat
// yields no result and restarts counting, and an unused mode code is dropped
// without effect. Matches are leftmost and non-overlapping: after a hit the
// window has to fill again before the next compare. The hit count saturates
// at 4095 and the line number at its 32-bit maximum. There is no clearing
// pass after reset. Configuration is written through a plain write port and
// must only change while the block is idle; pattern lengths above PATTERN_MAX
// act as PATTERN_MAX and a length of zero never matches.
module line_pattern_match_filter
	import lpmf_pkg::*;
#(
	parameter int unsigned PATTERN_MAX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// Text input channel.
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_beat_t              in_data,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_beat_t             out_data
);

	// Width able to hold a length from zero up to PATTERN_MAX.
	localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
	// Flattened pattern, widened so positions past the 16 stored bytes read as zero.
	localparam int unsigned PAT_BYTES = (PATTERN_MAX > 16) ? PATTERN_MAX : 16;
	localparam int unsigned PW = PAT_BYTES * 8;

	// Configuration registers.
	logic [63:0] pat_lo_q;
	logic [63:0] pat_hi_q;
	logic [4:0]  plen_q;
	logic [2:0]  fmode_q;
	logic [12:0] fval_q;
	logic        only_q;

	// Scan state.
	logic [7:0]  recent_q [PATTERN_MAX];
	logic [LW-1:0] fill_q;
	logic [11:0] match_cnt_q;
	logic [31:0] line_cnt_q;

	// Input stage and result stage.
	logic      valid_s1;
	in_beat_t  data_s1;
	logic      res_valid_s2;
	out_beat_t res_s2;

	// Stage-one decode and datapath.
	logic          s1_char;
	logic          s1_eol;
	logic          s1_new_file;
	logic          s1_has_result;
	logic          s1_go;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] fill_inc;
	logic [PW-1:0] pat_flat;
	logic [7:0]    pat_arr [PAT_BYTES];
	logic [7:0]    win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] pos_ok;
	logic          s1_hit;
	logic          s1_pass;
	logic [31:0]   line_next;
	out_beat_t     res_next;

	// ------------------------------------------------------------------
	// Configuration registers. Writes to indexes past the list are ignored.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			plen_q   <= 5'd1;
			fmode_q  <= FILT_NONE;
			fval_q   <= '0;
			only_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PATTERN_LOW:    pat_lo_q <= cfg_wdata;
				REG_PATTERN_HIGH:   pat_hi_q <= cfg_wdata;
				REG_PATTERN_LENGTH: plen_q   <= cfg_wdata[4:0];
				REG_FILTER_MODE:    fmode_q  <= cfg_wdata[2:0];
				REG_FILTER_VALUE:   fval_q   <= cfg_wdata[12:0];
				REG_ONLY_MATCHES:   only_q   <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake. A beat leaves stage one when it makes no result, or when
	// the result register is empty or being drained this cycle. The input
	// register refills in the same cycle it empties.
	// ------------------------------------------------------------------
	assign s1_go    = valid_s1 && (!s1_has_result || !res_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// ------------------------------------------------------------------
	// Beat decode. A newline byte inside a character beat ends the line.
	// ------------------------------------------------------------------
	always_comb begin
		s1_char     = (data_s1.mode == MODE_CHAR) && (data_s1.char_byte != NEWLINE_BYTE);
		s1_eol      = (data_s1.mode == MODE_EOL) ||
		              ((data_s1.mode == MODE_CHAR) && (data_s1.char_byte == NEWLINE_BYTE));
		s1_new_file = (data_s1.mode == MODE_NEW_FILE);
		s1_has_result = s1_char || s1_eol;
	end

	// ------------------------------------------------------------------
	// Window compare. The window as it stands after taking this byte has
	// the new byte at position 0. Position k holds the byte that must equal
	// pattern byte (length - 1 - k); positions at or past the length are
	// don't-cares.
	// ------------------------------------------------------------------
	assign pat_flat = PW'({pat_hi_q, pat_lo_q});

	always_comb begin
		for (int i = 0; i < PAT_BYTES; i++) begin
			pat_arr[i] = pat_flat[8*i +: 8];
		end
	end

	always_comb begin
		if (32'(plen_q) > 32'(PATTERN_MAX)) begin
			len_eff = LW'(PATTERN_MAX);
		end else begin
			len_eff = LW'(plen_q);
		end
	end

	always_comb begin
		win[0] = data_s1.char_byte;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win[k] = recent_q[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pos_ok[k] = 1'b1;
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (k + i + 1 == int'(len_eff)) begin
					pos_ok[k] = (win[k] == pat_arr[i]);
				end
			end
		end
	end

	// The fill count stops at the length, so adding one never overflows.
	assign fill_inc = (fill_q < len_eff) ? (fill_q + LW'(1)) : fill_q;
	assign s1_hit   = (len_eff != '0) && (fill_inc >= len_eff) && (&pos_ok);

	// ------------------------------------------------------------------
	// Line verdict on the count before this end of line clears it.
	// ------------------------------------------------------------------
	always_comb begin
		if (only_q) begin
			s1_pass = (match_cnt_q != '0);
		end else begin
			case (fmode_q)
				FILT_GT: s1_pass = {1'b0, match_cnt_q} >  fval_q;
				FILT_LT: s1_pass = {1'b0, match_cnt_q} <  fval_q;
				FILT_EQ: s1_pass = {1'b0, match_cnt_q} == fval_q;
				FILT_GE: s1_pass = {1'b0, match_cnt_q} >= fval_q;
				FILT_LE: s1_pass = {1'b0, match_cnt_q} <= fval_q;
				default: s1_pass = 1'b1;
			endcase
		end
	end

	assign line_next = (line_cnt_q != LINE_MAX) ? (line_cnt_q + 32'd1) : line_cnt_q;

	always_comb begin
		res_next = '0;
		if (s1_char) begin
			res_next.match_here = s1_hit;
		end else begin
			res_next.line_done   = 1'b1;
			res_next.line_passed = s1_pass;
			res_next.match_count = match_cnt_q;
			res_next.line_number = line_next;
		end
	end

	// ------------------------------------------------------------------
	// Scan state update, one beat per cycle while beats leave stage one.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				recent_q[k] <= '0;
			end
			fill_q      <= '0;
			match_cnt_q <= '0;
			line_cnt_q  <= '0;
		end else if (s1_go) begin
			if (s1_char) begin
				for (int k = 0; k < PATTERN_MAX; k++) begin
					recent_q[k] <= win[k];
				end
				if (s1_hit) begin
					fill_q <= '0;
					if (match_cnt_q != COUNT_MAX) begin
						match_cnt_q <= match_cnt_q + 12'd1;
					end
				end else begin
					fill_q <= fill_inc;
				end
			end else if (s1_eol || s1_new_file) begin
				for (int k = 0; k < PATTERN_MAX; k++) begin
					recent_q[k] <= '0;
				end
				fill_q      <= '0;
				match_cnt_q <= '0;
				line_cnt_q  <= s1_eol ? line_next : '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_go && s1_has_result) begin
			res_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_has_result) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// A hit empties the window and leaves a nonzero hit count behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_char && s1_hit) |=> (fill_q == '0 && match_cnt_q != '0))
		else $error("window or count wrong after a hit");

	// An end of line leaves the window empty and the count cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_eol) |=> (fill_q == '0 && match_cnt_q == '0))
		else $error("line state not cleared at end of line");

	// A new-file beat restarts line numbering and never produces a result beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_new_file) |=> (line_cnt_q == '0 &&
		res_valid_s2 == ($past(res_valid_s2) && !$past(out_ready))))
		else $error("new-file beat handled wrong");

	// An empty input register always takes a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

// ===== test/tb_line_pattern_match_filter.sv =====
// Self-checking testbench for the line pattern match filter.
`timescale 1ns / 1ps

// The bench streams text beats into the filter and checks every result beat
// against an expectation worked out by a predictor of its own. The predictor
// keeps a shadow copy of the configuration and of the per-line state (byte
// window, window fill, hit count, line counter). Expectations are queued in
// the order that text beats are accepted; each result beat taken from the
// block is compared field by field with the oldest one.
//
// The run starts with a short directed sequence, then goes through nine
// random phases under three idling regimes, each phase with its own pattern
// and filter settings. Configuration changes only while the block is idle.
module tb_line_pattern_match_filter;
	import lpmf_pkg::*;

	localparam int unsigned PATTERN_MAX = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned BEATS_PER_PHASE = 118;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RECEIVER_HOLD = 300;

	// Codes that the package does not name: spare filter modes pass every
	// line, and the spare input mode is dropped by the block.
	localparam logic [2:0] FILT_SPARE_6 = 3'd6;
	localparam logic [2:0] FILT_SPARE_7 = 3'd7;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Shadow of the block: configuration, line state and the queue of results
	// still owed by the block.
	class line_match_scoreboard;
		logic [63:0] pat_lo;
		logic [63:0] pat_hi;
		logic [4:0] pat_len;
		logic [2:0] filt_mode;
		logic [12:0] filt_value;
		logic only_hits;
		logic [7:0] window [PATTERN_MAX];
		int unsigned fill;
		logic [11:0] hits;
		logic [31:0] line_no;
		out_beat_t awaited[$];
		int unsigned errors;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			pat_len = 5'd1;
			filt_mode = FILT_NONE;
			filt_value = '0;
			only_hits = 1'b0;
			line_no = '0;
			errors = 0;
			restart_line();
		endfunction

		function void restart_line();
			foreach (window[i])
				window[i] = 8'h00;
			fill = 0;
			hits = '0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_PATTERN_LOW: pat_lo = data;
				REG_PATTERN_HIGH: pat_hi = data;
				REG_PATTERN_LENGTH: pat_len = data[4:0];
				REG_FILTER_MODE: filt_mode = data[2:0];
				REG_FILTER_VALUE: filt_value = data[12:0];
				REG_ONLY_MATCHES: only_hits = data[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] pattern_byte(int unsigned i);
			logic [127:0] all_bytes;
			all_bytes = {pat_hi, pat_lo};
			if (i >= PATTERN_MAX)
				return 8'h00;
			return all_bytes[8*i +: 8];
		endfunction

		// Lengths beyond the window act as a full window.
		function int unsigned used_length();
			return (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
		endfunction

		function bit line_passes(logic [11:0] count);
			if (only_hits)
				return count != 0;
			case (filt_mode)
				FILT_GT: return count > filt_value;
				FILT_LT: return count < filt_value;
				FILT_EQ: return count == filt_value;
				FILT_GE: return count >= filt_value;
				FILT_LE: return count <= filt_value;
				default: return 1'b1;
			endcase
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// Advances the shadow state by one accepted beat and queues the
		// result it owes, if any.
		function void note_beat(in_beat_t beat);
			logic [1:0] kind;
			int unsigned len;
			bit hit;
			out_beat_t res;
			kind = beat.mode;
			if (kind == MODE_CHAR && beat.char_byte == NEWLINE_BYTE)
				kind = MODE_EOL;
			res = '0;
			case (kind)
				MODE_CHAR: begin
					len = used_length();
					for (int i = PATTERN_MAX - 1; i > 0; i--)
						window[i] = window[i-1];
					window[0] = beat.char_byte;
					if (fill < len)
						fill++;
					hit = (len > 0) && (fill >= len);
					for (int i = 0; i < len; i++)
						if (window[len-1-i] != pattern_byte(i))
							hit = 1'b0;
					if (hit) begin
						fill = 0;
						if (hits != COUNT_MAX)
							hits++;
					end
					res.match_here = hit;
					awaited.push_back(res);
				end
				MODE_EOL: begin
					if (line_no != LINE_MAX)
						line_no++;
					res.line_done = 1'b1;
					res.line_passed = line_passes(hits);
					res.match_count = hits;
					res.line_number = line_no;
					awaited.push_back(res);
					restart_line();
				end
				MODE_NEW_FILE: begin
					restart_line();
					line_no = '0;
				end
				default: ;
			endcase
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, got);
				return;
			end
			want = awaited.pop_front();
			compare("match_here", want.match_here, got.match_here);
			compare("line_done", want.line_done, got.line_done);
			compare("line_passed", want.line_passed, got.line_passed);
			compare("match_count", want.match_count, got.match_count);
			compare("line_number", want.line_number, got.line_number);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;

	line_match_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_cycles;
	int unsigned text_beats;
	int unsigned cycle_count;

	line_pattern_match_filter #(
		.PATTERN_MAX(PATTERN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a run that has not finished by the limit has hung.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Receiver. Each cycle it decides whether to take a beat; a requested
	// hold-off keeps ready low for that many cycles, counted here.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// Offers one beat, after a random number of idle cycles, and returns at
	// the edge where it is accepted. Valid stays high afterwards so that the
	// next beat can follow without a gap.
	task automatic send_beat(input logic [1:0] kind, input logic [7:0] ch);
		in_beat_t beat;
		beat.mode = kind;
		beat.char_byte = ch;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_beat(beat);
		if (kind == MODE_CHAR || kind == MODE_EOL)
			text_beats++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_beat(MODE_CHAR, text[i]);
	endtask

	// Stops offering beats and waits until every owed result has arrived.
	// The extra cycles cover a new-file beat still in flight, which owes none.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(addr, data);
	endtask

	task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] len, input logic [2:0] fmode, input logic [12:0] fval,
			input logic only);
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LENGTH, 64'(len));
		write_reg(REG_FILTER_MODE, 64'(fmode));
		write_reg(REG_FILTER_VALUE, 64'(fval));
		write_reg(REG_ONLY_MATCHES, 64'(only));
		cfg_we <= 1'b0;
	endtask

	// Pattern bytes drawn from a two-letter alphabet, so that random text
	// built from them produces overlapping and near-miss occurrences.
	function automatic logic [63:0] narrow_bytes();
		logic [63:0] v;
		for (int i = 0; i < 8; i++)
			v[8*i +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
		return v;
	endfunction

	// One random line. Chunks are most often whole pattern occurrences, some
	// are cut short; the rest are single pattern bytes, arbitrary bytes and
	// beats of the spare mode. The line ends with an end-of-line mark, a
	// newline byte or a new-file mark that drops it.
	task automatic send_random_line();
		int unsigned gen_len;
		int unsigned pick;
		int unsigned cut;
		gen_len = sb.used_length();
		if (gen_len == 0)
			gen_len = 4;
		repeat ($urandom_range(6)) begin
			pick = $urandom_range(99);
			if (pick < 45)
				cut = gen_len;
			else if (pick < 60)
				cut = $urandom_range(gen_len - 1);
			else
				cut = 0;
			for (int i = 0; i < cut; i++)
				send_beat(MODE_CHAR, sb.pattern_byte(i));
			if (pick >= 60 && pick < 80)
				send_beat(MODE_CHAR, sb.pattern_byte($urandom_range(gen_len - 1)));
			else if (pick >= 80 && pick < 95)
				send_beat(MODE_CHAR, 8'($urandom_range(255)));
			else if (pick >= 95)
				send_beat(MODE_SPARE, 8'($urandom_range(255)));
		end
		pick = $urandom_range(99);
		if (pick < 80)
			send_beat(MODE_EOL, 8'($urandom_range(255)));
		else if (pick < 90)
			send_beat(MODE_CHAR, NEWLINE_BYTE);
		else
			send_beat(MODE_NEW_FILE, 8'($urandom_range(255)));
	endtask

	initial begin
		int unsigned phase_end;
		logic [63:0] rnd_lo;
		logic [63:0] rnd_hi;

		sb = new();
		send_idle_pct = 31;
		recv_idle_pct = 48;
		hold_cycles = 0;
		text_beats = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the pattern "aba": a match restarts the window so
		// the trailing "ba" does not count again, a newline byte ends the line,
		// an empty line fails the at-least-one filter, zero and all-ones bytes
		// are plain text, the spare mode is dropped, and a new-file mark drops
		// the open line and restarts line numbering.
		load_config(64'h0000_0000_0061_6261, 64'h0, 5'd3, FILT_GE, 13'd1, 1'b0);
		send_text("ababa");
		send_beat(MODE_CHAR, NEWLINE_BYTE);
		send_beat(MODE_EOL, 8'hFF);
		send_beat(MODE_CHAR, 8'h00);
		send_beat(MODE_CHAR, 8'hFF);
		send_beat(MODE_SPARE, 8'hAA);
		send_text("aba");
		send_beat(MODE_EOL, 8'h00);
		send_text("ab");
		send_beat(MODE_NEW_FILE, 8'h55);
		send_text("a");
		send_beat(MODE_EOL, 8'h61);

		// Random phases. The settings walk through every filter mode, the
		// spare ones too, the length extremes (zero, one, full window and
		// values beyond it), both threshold extremes and the only-matches
		// override.
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				settle();
				rnd_lo = {$urandom, $urandom};
				rnd_hi = {$urandom, $urandom};
				case (3 * regime + k)
					0: load_config(64'h0, 64'h0, 5'd1, FILT_NONE, 13'd0, 1'b0);
					1: load_config(rnd_lo, rnd_hi, 5'd16, FILT_GT, 13'd0, 1'b0);
					2: load_config(narrow_bytes(), narrow_bytes(), 5'd2, FILT_LT, 13'd4096,
						1'b0);
					3: load_config(rnd_lo, rnd_hi, 5'd0, FILT_EQ, 13'd0, 1'b0);
					4: load_config(rnd_lo, rnd_hi, 5'd31, FILT_GE, 13'd4096, 1'b1);
					5: load_config(narrow_bytes(), narrow_bytes(), 5'd3, FILT_LE,
						13'($urandom_range(6)), 1'b0);
					6: load_config(rnd_lo, narrow_bytes(), 5'd17, FILT_SPARE_6,
						13'($urandom_range(4096)), 1'b0);
					7: load_config(narrow_bytes(), narrow_bytes(), 5'($urandom_range(1, 5)),
						FILT_EQ, 13'($urandom_range(4)), 1'b0);
					default: load_config(narrow_bytes(), rnd_hi, 5'($urandom_range(1, 12)),
						FILT_SPARE_7, 13'($urandom_range(4096)), 1'b1);
				endcase
				// With neither side idling, a long receiver stall lets the
				// block fill up and push back on the sender.
				if (regime == 2 && k == 0)
					hold_cycles = RECEIVER_HOLD;
				phase_end = text_beats + BEATS_PER_PHASE;
				while (text_beats < phase_end)
					send_random_line();
			end
		end

		settle();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lpmf_pkg.sv
sv/line_pattern_match_filter.sv
test/tb_line_pattern_match_filter.sv
